/* hw/rtl/tcw_pkg.sv */
`default_nettype none

package tcw_pkg;

  // Field widths of the ports
  localparam int unsigned ReqW     = 3;
  localparam int unsigned CharW    = 8;
  localparam int unsigned AttrW    = 8;
  localparam int unsigned ColorW   = 4;
  localparam int unsigned ColW     = 7;
  localparam int unsigned RowW     = 5;
  localparam int unsigned IdxOutW  = 11;
  localparam int unsigned CfgIdxW  = 1;
  // Linear cell index wide enough for the largest screen (127 x 31)
  localparam int unsigned CellIdxW = 12;
  localparam int unsigned CellW    = CharW + AttrW;

  // Default geometry
  localparam int unsigned DefCols = 80;
  localparam int unsigned DefRows = 25;

  // Depth of the decoupling queues
  localparam int unsigned QueueDepth = 2;

  localparam logic [CharW-1:0] SpaceChar   = 8'h20;
  localparam logic [CharW-1:0] NewlineChar = 8'h0A;
  localparam logic [AttrW-1:0] ResetAttr   = 8'h0F;
  localparam logic [ColorW-1:0] ResetFg    = 4'hF;
  localparam logic [ColorW-1:0] ResetBg    = 4'h0;

  typedef enum logic [ReqW-1:0] {
    REQ_PUT_CHAR   = 3'd0,
    REQ_NEWLINE    = 3'd1,
    REQ_BACKSPACE  = 3'd2,
    REQ_CLEAR      = 3'd3,
    REQ_SET_CURSOR = 3'd4,
    REQ_READ_CELL  = 3'd5
  } req_type_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FG_COLOR = 1'b0,
    CFG_BG_COLOR = 1'b1
  } cfg_reg_e;

  // Classified operation handed from the front to the back
  typedef enum logic [2:0] {
    OP_PUT,
    OP_LF_BYTE,
    OP_NEWLINE,
    OP_BACKSPACE,
    OP_CLEAR,
    OP_SET_CURSOR,
    OP_READ,
    OP_NOP
  } op_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_READ_WAIT,
    ST_FILL,
    ST_EMIT
  } state_e;

  typedef struct packed {
    op_e                 op;
    logic [CharW-1:0]    ch;
    logic [ColW-1:0]     tcol;
    logic [RowW-1:0]     trow;
    logic                t_ok;
    logic [CellIdxW-1:0] t_idx;
  } cmd_t;

  typedef struct packed {
    logic               wrote;
    logic [IdxOutW-1:0] idx;
    logic [CharW-1:0]   ch;
    logic [AttrW-1:0]   attr;
    logic [ColW-1:0]    ccol;
    logic [RowW-1:0]    crow;
    logic               cleared;
  } res_t;

endpackage

`default_nettype wire

/* hw/rtl/tcw_fifo.sv */
`default_nettype none

module tcw_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = tcw_pkg::QueueDepth
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [Width-1:0] data_o,
  output logic                  empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW:0]    wr_q, wr_d, rd_q, rd_d;
  logic             do_push, do_pop;

  assign empty_o = (wr_q == rd_q);
  assign full_o  = (wr_q[PtrW] != rd_q[PtrW]) && (wr_q[PtrW-1:0] == rd_q[PtrW-1:0]);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q[PtrW-1:0]];

  always_comb begin
    wr_d = wr_q;
    rd_d = rd_q;
    if (do_push) begin
      wr_d = (wr_q[PtrW-1:0] == PtrW'(Depth - 1)) ?
             {~wr_q[PtrW], {PtrW{1'b0}}} : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q[PtrW-1:0] == PtrW'(Depth - 1)) ?
             {~rd_q[PtrW], {PtrW{1'b0}}} : rd_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q[PtrW-1:0]] <= data_i;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/tcw_front.sv */
`default_nettype none

module tcw_front #(
  parameter int unsigned Cols = tcw_pkg::DefCols,
  parameter int unsigned Rows = tcw_pkg::DefRows
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [tcw_pkg::ReqW-1:0]    req_type_i,
  input  wire logic [tcw_pkg::CharW-1:0]   char_code_i,
  input  wire logic [tcw_pkg::ColW-1:0]    target_col_i,
  input  wire logic [tcw_pkg::RowW-1:0]    target_row_i,
  output tcw_pkg::cmd_t                    cmd_o,
  output logic                             cmd_push_o,
  input  wire logic                        cmd_full_i
);

  logic          valid_q, valid_d;
  tcw_pkg::cmd_t cmd_q, cmd_d;
  logic          take;

  // Full in the back's reset sweep or when the held item meets a full queue
  assign full       = !en_i || (valid_q && cmd_full_i);
  assign take       = push && !full;
  assign cmd_o      = cmd_q;
  assign cmd_push_o = valid_q;

  always_comb begin
    cmd_d       = cmd_q;
    cmd_d.ch    = char_code_i;
    cmd_d.tcol  = target_col_i;
    cmd_d.trow  = target_row_i;
    cmd_d.t_ok  = (target_col_i < tcw_pkg::ColW'(Cols)) &&
                  (target_row_i < tcw_pkg::RowW'(Rows));
    cmd_d.t_idx = tcw_pkg::CellIdxW'(target_row_i) * tcw_pkg::CellIdxW'(Cols) +
                  tcw_pkg::CellIdxW'(target_col_i);
    case (tcw_pkg::req_type_e'(req_type_i))
      tcw_pkg::REQ_PUT_CHAR: begin
        cmd_d.op = (char_code_i == tcw_pkg::NewlineChar) ?
                   tcw_pkg::OP_LF_BYTE : tcw_pkg::OP_PUT;
      end
      tcw_pkg::REQ_NEWLINE:    cmd_d.op = tcw_pkg::OP_NEWLINE;
      tcw_pkg::REQ_BACKSPACE:  cmd_d.op = tcw_pkg::OP_BACKSPACE;
      tcw_pkg::REQ_CLEAR:      cmd_d.op = tcw_pkg::OP_CLEAR;
      tcw_pkg::REQ_SET_CURSOR: cmd_d.op = tcw_pkg::OP_SET_CURSOR;
      tcw_pkg::REQ_READ_CELL:  cmd_d.op = tcw_pkg::OP_READ;
      default:                 cmd_d.op = tcw_pkg::OP_NOP;
    endcase
  end

  always_comb begin
    if (take) begin
      valid_d = 1'b1;
    end else if (!cmd_full_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/tcw_back.sv */
`default_nettype none

module tcw_back #(
  parameter int unsigned Cols = tcw_pkg::DefCols,
  parameter int unsigned Rows = tcw_pkg::DefRows
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [tcw_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [tcw_pkg::ColorW-1:0]    cfg_data_i,
  input  wire tcw_pkg::cmd_t                 cmd_i,
  input  wire logic                          cmd_empty_i,
  output logic                               cmd_pop_o,
  output tcw_pkg::res_t                      res_o,
  output logic                               res_push_o,
  input  wire logic                          res_full_i,
  output logic                               ready_o
);

  localparam int unsigned Cells = Cols * Rows;
  localparam int unsigned AddrW = $clog2(Cells);
  localparam int unsigned RowXW = tcw_pkg::RowW + 1;

  tcw_pkg::state_e state_q, state_d;
  tcw_pkg::cmd_t   cmd_q, cmd_d;
  tcw_pkg::res_t   res_q, res_d;

  logic [tcw_pkg::ColW-1:0]   col_q, col_d, scol_q, scol_d;
  logic [tcw_pkg::RowW-1:0]   row_q, row_d;
  logic [tcw_pkg::ColorW-1:0] fg_q, bg_q;
  logic [AddrW-1:0]           cnt_q, cnt_d, base_q, base_d;

  logic [tcw_pkg::CellW-1:0] mem [Cells];
  logic [tcw_pkg::CellW-1:0] rdata_q;
  logic                      we, re;
  logic [AddrW-1:0]          waddr, raddr, put_addr, bs_addr, scan_addr;
  logic [tcw_pkg::CellW-1:0] wdata;

  logic [tcw_pkg::AttrW-1:0] attr;
  logic [tcw_pkg::ColW-1:0]  put_col, col_dec;
  logic [RowXW-1:0]          put_row_x, row_inc;
  logic [tcw_pkg::RowW-1:0]  put_row, row_dec;
  logic                      go, cnt_last, nl_wrap, bs_scan, scan_more;

  assign attr      = {bg_q, fg_q};
  assign cfg_ready = 1'b1;
  assign ready_o   = (state_q != tcw_pkg::ST_INIT);
  assign res_o     = res_q;

  // Shared decisions of the sequencer
  assign go        = !cmd_empty_i && !res_full_i;
  assign cnt_last  = (cnt_q == AddrW'(Cells - 1));
  assign row_inc   = RowXW'(row_q) + 1'b1;
  assign nl_wrap   = (row_inc >= RowXW'(Rows));
  assign bs_scan   = (col_q == '0) && (row_q != '0);
  assign scan_more = (scol_q != '0) && (rdata_q[tcw_pkg::CharW-1:0] == tcw_pkg::SpaceChar);
  assign col_dec   = col_q - 1'b1;
  assign row_dec   = row_q - 1'b1;

  // Wrap the cursor of a put: past the last column first, then past the last row
  always_comb begin
    if (col_q >= tcw_pkg::ColW'(Cols)) begin
      put_col   = '0;
      put_row_x = row_inc;
    end else begin
      put_col   = col_q;
      put_row_x = RowXW'(row_q);
    end
    if (put_row_x >= RowXW'(Rows)) begin
      put_row_x = '0;
    end
  end

  assign put_row   = put_row_x[tcw_pkg::RowW-1:0];
  assign put_addr  = AddrW'(put_row) * AddrW'(Cols) + AddrW'(put_col);
  assign bs_addr   = AddrW'(row_q) * AddrW'(Cols) + AddrW'(col_dec);
  assign scan_addr = base_q + AddrW'(scol_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tcw_pkg::ST_INIT: begin
        if (cnt_last) state_d = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_IDLE: begin
        if (go) state_d = tcw_pkg::ST_EXEC;
      end
      tcw_pkg::ST_EXEC: begin
        case (cmd_q.op)
          tcw_pkg::OP_NEWLINE:   state_d = nl_wrap ? tcw_pkg::ST_FILL : tcw_pkg::ST_EMIT;
          tcw_pkg::OP_BACKSPACE: state_d = bs_scan ? tcw_pkg::ST_SCAN_RD : tcw_pkg::ST_EMIT;
          tcw_pkg::OP_CLEAR:     state_d = tcw_pkg::ST_FILL;
          tcw_pkg::OP_READ:      state_d = cmd_q.t_ok ? tcw_pkg::ST_READ_WAIT : tcw_pkg::ST_EMIT;
          default:               state_d = tcw_pkg::ST_EMIT;
        endcase
      end
      tcw_pkg::ST_SCAN_RD:   state_d = tcw_pkg::ST_SCAN_CHK;
      tcw_pkg::ST_SCAN_CHK:  state_d = scan_more ? tcw_pkg::ST_SCAN_RD : tcw_pkg::ST_EMIT;
      tcw_pkg::ST_READ_WAIT: state_d = tcw_pkg::ST_EMIT;
      tcw_pkg::ST_FILL: begin
        if (cnt_last) state_d = tcw_pkg::ST_EMIT;
      end
      tcw_pkg::ST_EMIT:      state_d = tcw_pkg::ST_IDLE;
      default:               state_d = tcw_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    cmd_d      = cmd_q;
    res_d      = res_q;
    col_d      = col_q;
    row_d      = row_q;
    scol_d     = scol_q;
    cnt_d      = cnt_q;
    base_d     = base_q;
    we         = 1'b0;
    re         = 1'b0;
    waddr      = cnt_q;
    wdata      = {attr, tcw_pkg::SpaceChar};
    raddr      = scan_addr;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    case (state_q)
      tcw_pkg::ST_INIT: begin
        we    = 1'b1;
        wdata = {tcw_pkg::ResetAttr, tcw_pkg::SpaceChar};
        cnt_d = cnt_last ? '0 : cnt_q + 1'b1;
      end
      tcw_pkg::ST_IDLE: begin
        if (go) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
        end
      end
      tcw_pkg::ST_EXEC: begin
        res_d = '0;
        case (cmd_q.op)
          tcw_pkg::OP_PUT: begin
            we         = 1'b1;
            waddr      = put_addr;
            wdata      = {attr, cmd_q.ch};
            res_d.wrote = 1'b1;
            res_d.idx  = tcw_pkg::IdxOutW'(put_addr);
            res_d.ch   = cmd_q.ch;
            res_d.attr = attr;
            col_d      = put_col + 1'b1;
            row_d      = put_row;
          end
          tcw_pkg::OP_LF_BYTE: begin
            col_d = '0;
            if (row_q < tcw_pkg::RowW'(Rows)) row_d = row_inc[tcw_pkg::RowW-1:0];
          end
          tcw_pkg::OP_NEWLINE: begin
            col_d = '0;
            if (nl_wrap) begin
              row_d         = '0;
              res_d.cleared = 1'b1;
            end else begin
              row_d = row_inc[tcw_pkg::RowW-1:0];
            end
          end
          tcw_pkg::OP_BACKSPACE: begin
            if (col_q != '0) begin
              col_d = col_dec;
              if (row_q < tcw_pkg::RowW'(Rows)) begin
                we          = 1'b1;
                waddr       = bs_addr;
                res_d.wrote = 1'b1;
                res_d.idx   = tcw_pkg::IdxOutW'(bs_addr);
                res_d.ch    = tcw_pkg::SpaceChar;
                res_d.attr  = attr;
              end
            end else if (row_q != '0) begin
              // Start the scan at the last column of the previous row
              row_d  = row_dec;
              scol_d = tcw_pkg::ColW'(Cols - 1);
              base_d = AddrW'(row_dec) * AddrW'(Cols);
            end
          end
          tcw_pkg::OP_CLEAR: begin
            col_d         = '0;
            row_d         = '0;
            res_d.cleared = 1'b1;
          end
          tcw_pkg::OP_SET_CURSOR: begin
            if (cmd_q.t_ok) begin
              col_d = cmd_q.tcol;
              row_d = cmd_q.trow;
            end
          end
          tcw_pkg::OP_READ: begin
            if (cmd_q.t_ok) begin
              re        = 1'b1;
              raddr     = AddrW'(cmd_q.t_idx);
              res_d.idx = tcw_pkg::IdxOutW'(cmd_q.t_idx);
            end
          end
          default: begin
          end
        endcase
        res_d.ccol = col_d;
        res_d.crow = row_d;
      end
      tcw_pkg::ST_SCAN_RD: begin
        re = 1'b1;
      end
      tcw_pkg::ST_SCAN_CHK: begin
        if (scan_more) begin
          scol_d = scol_q - 1'b1;
        end else begin
          // Blank the cell the scan stopped on
          we          = 1'b1;
          waddr       = scan_addr;
          col_d       = scol_q;
          res_d.wrote = 1'b1;
          res_d.idx   = tcw_pkg::IdxOutW'(scan_addr);
          res_d.ch    = tcw_pkg::SpaceChar;
          res_d.attr  = attr;
          res_d.ccol  = scol_q;
          res_d.crow  = row_q;
        end
      end
      tcw_pkg::ST_READ_WAIT: begin
        res_d.ch   = rdata_q[tcw_pkg::CharW-1:0];
        res_d.attr = rdata_q[tcw_pkg::CellW-1:tcw_pkg::CharW];
      end
      tcw_pkg::ST_FILL: begin
        we    = 1'b1;
        cnt_d = cnt_last ? '0 : cnt_q + 1'b1;
      end
      tcw_pkg::ST_EMIT: begin
        res_push_o = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tcw_pkg::ST_INIT;
      col_q   <= '0;
      row_q   <= '0;
      cnt_q   <= '0;
      fg_q    <= tcw_pkg::ResetFg;
      bg_q    <= tcw_pkg::ResetBg;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
      cnt_q   <= cnt_d;
      if (cfg_valid && cfg_ready) begin
        case (tcw_pkg::cfg_reg_e'(cfg_index_i))
          tcw_pkg::CFG_FG_COLOR: fg_q <= cfg_data_i;
          tcw_pkg::CFG_BG_COLOR: bg_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    res_q  <= res_d;
    scol_q <= scol_d;
    base_q <= base_d;
  end

  // Cell store: one write port, one read port with registered data
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/text_console_writer.sv */
// Path: with the back idle, a simple command passes the front register, the command
//   queue, the back's IDLE, EXEC and EMIT states and the result queue before it shows.
// Sequencing: the back runs IDLE, EXEC and EMIT on put, newline, set cursor and most
//   backspaces, adds READ_WAIT on read cell, a SCAN_RD and SCAN_CHK pair per column read
//   on a backspace row scan, and a FILL pass on clear or a newline that wraps (one store
//   write per cycle). Reset: the cursor homes, colors return to 0x0F, and a pass writes
//   spaces into every cell; full stays high until that pass ends.
`default_nettype none

module text_console_writer #(
  parameter int unsigned Cols = tcw_pkg::DefCols,
  parameter int unsigned Rows = tcw_pkg::DefRows
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Configuration write channel
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [tcw_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [tcw_pkg::ColorW-1:0]    cfg_data_i,
  // Command side
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [tcw_pkg::ReqW-1:0]      req_type_i,
  input  wire logic [tcw_pkg::CharW-1:0]     char_code_i,
  input  wire logic [tcw_pkg::ColW-1:0]      target_col_i,
  input  wire logic [tcw_pkg::RowW-1:0]      target_row_i,
  // Result side
  output logic                               empty,
  input  wire logic                          pop,
  output logic                               wrote_cell_o,
  output logic [tcw_pkg::IdxOutW-1:0]        cell_index_o,
  output logic [tcw_pkg::CharW-1:0]          cell_char_o,
  output logic [tcw_pkg::AttrW-1:0]          cell_attr_o,
  output logic [tcw_pkg::ColW-1:0]           cursor_col_o,
  output logic [tcw_pkg::RowW-1:0]           cursor_row_o,
  output logic                               screen_cleared_o
);

  localparam int unsigned CmdW = $bits(tcw_pkg::cmd_t);
  localparam int unsigned ResW = $bits(tcw_pkg::res_t);

  tcw_pkg::cmd_t front_cmd, queue_cmd;
  tcw_pkg::res_t back_res, out_res;
  logic          front_push, cmd_full, cmd_empty, cmd_pop;
  logic          res_push, res_full, back_ready;

  // Front: decode each command transfer and range-check its target
  tcw_front #(
    .Cols (Cols),
    .Rows (Rows)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (back_ready),
    .push         (push),
    .full         (full),
    .req_type_i   (req_type_i),
    .char_code_i  (char_code_i),
    .target_col_i (target_col_i),
    .target_row_i (target_row_i),
    .cmd_o        (front_cmd),
    .cmd_push_o   (front_push),
    .cmd_full_i   (cmd_full)
  );

  // Short queue so the front keeps taking commands while the back walks the store
  tcw_fifo #(
    .Width (CmdW),
    .Depth (tcw_pkg::QueueDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .data_i  (front_cmd),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (queue_cmd),
    .empty_o (cmd_empty)
  );

  // Back: cursor, colors, cell store and the sequencer that drives them
  tcw_back #(
    .Cols (Cols),
    .Rows (Rows)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (queue_cmd),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_o       (back_res),
    .res_push_o  (res_push),
    .res_full_i  (res_full),
    .ready_o     (back_ready)
  );

  // Result queue: holds finished results until the consumer takes them
  tcw_fifo #(
    .Width (ResW),
    .Depth (tcw_pkg::QueueDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (back_res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_res),
    .empty_o (empty)
  );

  assign wrote_cell_o     = out_res.wrote;
  assign cell_index_o     = out_res.idx;
  assign cell_char_o      = out_res.ch;
  assign cell_attr_o      = out_res.attr;
  assign cursor_col_o     = out_res.ccol;
  assign cursor_row_o     = out_res.crow;
  assign screen_cleared_o = out_res.cleared;

endmodule

`default_nettype wire

/* verif/console_checker.sv */
module console_checker #(
  parameter int unsigned Cols = tcw_pkg::DefCols,
  parameter int unsigned Rows = tcw_pkg::DefRows
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [tcw_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [tcw_pkg::ColorW-1:0]  cfg_data_i,
  input  logic                        push,
  input  logic                        full,
  input  logic [tcw_pkg::ReqW-1:0]    req_type_i,
  input  logic [tcw_pkg::CharW-1:0]   char_code_i,
  input  logic [tcw_pkg::ColW-1:0]    target_col_i,
  input  logic [tcw_pkg::RowW-1:0]    target_row_i,
  input  logic                        empty,
  input  logic                        pop,
  input  logic                        wrote_cell_i,
  input  logic [tcw_pkg::IdxOutW-1:0] cell_index_i,
  input  logic [tcw_pkg::CharW-1:0]   cell_char_i,
  input  logic [tcw_pkg::AttrW-1:0]   cell_attr_i,
  input  logic [tcw_pkg::ColW-1:0]    cursor_col_i,
  input  logic [tcw_pkg::RowW-1:0]    cursor_row_i,
  input  logic                        screen_cleared_i,
  output int unsigned                 fail_count_o,
  output int unsigned                 pending_o
);
  import tcw_pkg::*;

  localparam int unsigned Cells = Cols * Rows;

  // Screen image: character in the low byte, attribute in the high byte
  logic [CellW-1:0]  screen_mem [Cells];
  int                cur_col;
  int                cur_row;
  logic [ColorW-1:0] fg_color;
  logic [ColorW-1:0] bg_color;
  res_t              cell_reports_q [$];
  int unsigned       mismatches = 0;

  assign fail_count_o = mismatches;

  function automatic void fill_screen(input logic [AttrW-1:0] attr);
    for (int i = 0; i < Cells; i++) screen_mem[i] = {attr, SpaceChar};
  endfunction

  // Store one cell and report it
  function automatic void write_cell(inout res_t r, input int idx,
                                     input logic [CharW-1:0] ch,
                                     input logic [AttrW-1:0] attr);
    if (idx < Cells) screen_mem[idx] = {attr, ch};
    r.wrote = 1'b1;
    r.idx   = idx[IdxOutW-1:0];
    r.ch    = ch;
    r.attr  = attr;
  endfunction

  // Advance the console by one command and return the report it produces
  function automatic res_t run_console_cmd(input logic [ReqW-1:0] req,
                                           input logic [CharW-1:0] ch,
                                           input logic [ColW-1:0] tcol,
                                           input logic [RowW-1:0] trow);
    res_t             r;
    logic [AttrW-1:0] attr;
    int               idx;
    r    = '0;
    attr = {bg_color, fg_color};
    case (req)
      REQ_PUT_CHAR: begin
        if (ch == NewlineChar) begin
          cur_col = 0;
          if (cur_row < Rows) cur_row++;
        end else begin
          if (cur_col >= Cols) begin
            cur_col = 0;
            cur_row++;
          end
          if (cur_row >= Rows) cur_row = 0;
          write_cell(r, cur_row * Cols + cur_col, ch, attr);
          cur_col++;
        end
      end
      REQ_NEWLINE: begin
        cur_col = 0;
        cur_row++;
        if (cur_row >= Rows) begin
          fill_screen(attr);
          cur_row   = 0;
          r.cleared = 1'b1;
        end
      end
      REQ_BACKSPACE: begin
        if (cur_col > 0) begin
          cur_col--;
          if (cur_row < Rows) write_cell(r, cur_row * Cols + cur_col, SpaceChar, attr);
        end else if (cur_row > 0) begin
          if (cur_row > Rows) cur_row = Rows;
          cur_row--;
          cur_col = Cols - 1;
          // walk back over trailing blanks of the previous row
          while (cur_col > 0 && screen_mem[cur_row * Cols + cur_col][CharW-1:0] == SpaceChar)
            cur_col--;
          write_cell(r, cur_row * Cols + cur_col, SpaceChar, attr);
        end
      end
      REQ_CLEAR: begin
        fill_screen(attr);
        cur_col   = 0;
        cur_row   = 0;
        r.cleared = 1'b1;
      end
      REQ_SET_CURSOR: begin
        if (tcol < Cols && trow < Rows) begin
          cur_col = tcol;
          cur_row = trow;
        end
      end
      REQ_READ_CELL: begin
        if (tcol < Cols && trow < Rows) begin
          idx    = trow * Cols + tcol;
          r.idx  = idx[IdxOutW-1:0];
          r.ch   = screen_mem[idx][CharW-1:0];
          r.attr = screen_mem[idx][CellW-1:CharW];
        end
      end
      default: ;
    endcase
    r.ccol = cur_col[ColW-1:0];
    r.crow = cur_row[RowW-1:0];
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      fill_screen(ResetAttr);
      cur_col  = 0;
      cur_row  = 0;
      fg_color = ResetFg;
      bg_color = ResetBg;
      cell_reports_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index_i == CFG_FG_COLOR) fg_color = cfg_data_i;
        else bg_color = cfg_data_i;
      end
      if (pop && !empty) begin
        if (cell_reports_q.size() == 0) begin
          mismatches++;
          $display("%0t: result transfer with nothing predicted: expected none, actual %0h",
                   $time, {wrote_cell_i, cell_index_i, cell_char_i, cell_attr_i,
                           cursor_col_i, cursor_row_i, screen_cleared_i});
        end else begin
          want = cell_reports_q.pop_front();
          check_field("wrote_cell", 32'(want.wrote), 32'(wrote_cell_i));
          check_field("cell_index", 32'(want.idx), 32'(cell_index_i));
          check_field("cell_char", 32'(want.ch), 32'(cell_char_i));
          check_field("cell_attr", 32'(want.attr), 32'(cell_attr_i));
          check_field("cursor_col", 32'(want.ccol), 32'(cursor_col_i));
          check_field("cursor_row", 32'(want.crow), 32'(cursor_row_i));
          check_field("screen_cleared", 32'(want.cleared), 32'(screen_cleared_i));
        end
      end
      if (push && !full)
        cell_reports_q.push_back(run_console_cmd(req_type_i, char_code_i,
                                                 target_col_i, target_row_i));
      pending_o <= cell_reports_q.size();
    end
  end

endmodule

/* verif/tb.sv */
module tb;
  import tcw_pkg::*;

  // Run shape
  localparam int unsigned CycleLimit     = 1_000_000;
  localparam int unsigned PhaseCount     = 8;
  localparam int unsigned ItemsPerPhase  = 200;
  localparam int unsigned HoldPhase      = 2;
  localparam int unsigned LongHoldCycles = 400;
  localparam int unsigned DrainCycles    = 32;

  // Request codes the block leaves unused
  localparam logic [ReqW-1:0] ReqSpareLo = 3'd6;
  localparam logic [ReqW-1:0] ReqSpareHi = 3'd7;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [ColorW-1:0]  cfg_data_i;
  logic               push;
  logic               full;
  logic [ReqW-1:0]    req_type_i;
  logic [CharW-1:0]   char_code_i;
  logic [ColW-1:0]    target_col_i;
  logic [RowW-1:0]    target_row_i;
  logic               empty;
  logic               pop;
  logic               wrote_cell_o;
  logic [IdxOutW-1:0] cell_index_o;
  logic [CharW-1:0]   cell_char_o;
  logic [AttrW-1:0]   cell_attr_o;
  logic [ColW-1:0]    cursor_col_o;
  logic [RowW-1:0]    cursor_row_o;
  logic               screen_cleared_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned items_sent    = 0;
  bit          quiet         = 1'b0;
  bit          long_hold_req = 1'b0;

  text_console_writer DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .push             (push),
    .full             (full),
    .req_type_i       (req_type_i),
    .char_code_i      (char_code_i),
    .target_col_i     (target_col_i),
    .target_row_i     (target_row_i),
    .empty            (empty),
    .pop              (pop),
    .wrote_cell_o     (wrote_cell_o),
    .cell_index_o     (cell_index_o),
    .cell_char_o      (cell_char_o),
    .cell_attr_o      (cell_attr_o),
    .cursor_col_o     (cursor_col_o),
    .cursor_row_o     (cursor_row_o),
    .screen_cleared_o (screen_cleared_o)
  );

  // Watch both queue sides and the register channel; predict and compare
  console_checker u_console_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .push             (push),
    .full             (full),
    .req_type_i       (req_type_i),
    .char_code_i      (char_code_i),
    .target_col_i     (target_col_i),
    .target_row_i     (target_row_i),
    .empty            (empty),
    .pop              (pop),
    .wrote_cell_i     (wrote_cell_o),
    .cell_index_i     (cell_index_o),
    .cell_char_i      (cell_char_o),
    .cell_attr_i      (cell_attr_o),
    .cursor_col_i     (cursor_col_o),
    .cursor_row_i     (cursor_row_o),
    .screen_cleared_i (screen_cleared_o),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hold the sender low for a gap of the length that the caller gives
  task automatic pause_sender(input int unsigned n);
    push <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Offer one command and hold it until the block takes it; return on the transfer
  // edge, or after a random gap with push low, so the caller can change push in that step
  task automatic send_cmd(input logic [ReqW-1:0] req, input logic [CharW-1:0] ch,
                          input logic [ColW-1:0] col, input logic [RowW-1:0] row);
    push         <= 1'b1;
    req_type_i   <= req;
    char_code_i  <= ch;
    target_col_i <= col;
    target_row_i <= row;
    do @(posedge clk_i); while (full);
    items_sent++;
    // drop in a random gap now and then, except in the closing phase
    if (!quiet && $urandom_range(15, 0) == 0) pause_sender($urandom_range(19, 1));
  endtask

  // Stop offering and wait until every predicted result has been popped.
  // The pending count is registered, so the loop waits on the clock before it looks.
  task automatic wait_for_results();
    push <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Leave cfg_valid high on return; the caller lowers it
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ColorW-1:0] data);
    cfg_valid   <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  task automatic set_colors(input logic [ColorW-1:0] fg, input logic [ColorW-1:0] bg);
    write_reg(CFG_FG_COLOR, fg);
    write_reg(CFG_BG_COLOR, bg);
    cfg_valid <= 1'b0;
  endtask

  // A run of text: mostly printable bytes with blanks mixed in, usually
  // short, sometimes long enough to wrap past the last column
  task automatic send_text_line();
    int unsigned      len;
    int unsigned      kind;
    logic [CharW-1:0] ch;
    len = ($urandom_range(3, 0) == 0) ? $urandom_range(90, 1) : $urandom_range(12, 1);
    repeat (len) begin
      kind = $urandom_range(19, 0);
      if (kind < 14) ch = CharW'($urandom_range(8'h7E, 8'h21));
      else if (kind < 19) ch = SpaceChar;
      else ch = CharW'($urandom);
      send_cmd(REQ_PUT_CHAR, ch, ColW'($urandom), RowW'($urandom));
    end
    // end the line with a newline byte, a newline command, or nothing
    kind = $urandom_range(3, 0);
    if (kind < 2) send_cmd(REQ_PUT_CHAR, NewlineChar, ColW'($urandom), RowW'($urandom));
    else if (kind == 2) send_cmd(REQ_NEWLINE, CharW'($urandom), ColW'($urandom),
                                 RowW'($urandom));
  endtask

  // One command of any kind; targets stay on screen most of the time
  task automatic send_random_cmd();
    int unsigned     pick;
    logic [ReqW-1:0] req;
    logic [ColW-1:0] col;
    logic [RowW-1:0] row;
    pick = $urandom_range(99, 0);
    col  = ColW'($urandom_range(DefCols - 1, 0));
    row  = RowW'($urandom_range(DefRows - 1, 0));
    if ($urandom_range(3, 0) == 0) begin
      col = ColW'($urandom);
      row = RowW'($urandom);
    end
    if (pick < 20) req = REQ_PUT_CHAR;
    else if (pick < 34) req = REQ_NEWLINE;
    else if (pick < 56) req = REQ_BACKSPACE;
    else if (pick < 57) req = REQ_CLEAR;
    else if (pick < 70) req = REQ_SET_CURSOR;
    else if (pick < 95) req = REQ_READ_CELL;
    else req = ReqW'($urandom_range(ReqSpareHi, ReqSpareLo));
    send_cmd(req, CharW'($urandom), col, row);
  endtask

  // Receiver: pop in random bursts, with one long hold-off on request so the
  // block backs up and pushes back on the sender
  initial begin : result_sink
    int unsigned idle_left;
    bit          hold_served;
    idle_left   = 0;
    hold_served = 1'b0;
    pop <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req && !hold_served) begin
        hold_served = 1'b1;
        idle_left   = LongHoldCycles;
      end else if (idle_left == 0 && !quiet && $urandom_range(15, 0) == 0) begin
        idle_left = $urandom_range(19, 1);
      end
      if (idle_left > 0) begin
        pop <= 1'b0;
        idle_left--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Cap the run length
  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    int unsigned       phase_end;
    logic [ColorW-1:0] fg;
    logic [ColorW-1:0] bg;
    rst_ni       <= 1'b0;
    cfg_valid    <= 1'b0;
    cfg_index_i  <= CFG_FG_COLOR;
    cfg_data_i   <= '0;
    push         <= 1'b0;
    req_type_i   <= REQ_PUT_CHAR;
    char_code_i  <= '0;
    target_col_i <= '0;
    target_row_i <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed pass under the reset colors. The block clears its store after
    // reset and keeps full high meanwhile, so the first transfer just waits.
    send_cmd(REQ_READ_CELL, '0, '0, '0);              // reset contents
    send_cmd(REQ_READ_CELL, '0, 7'd127, 5'd31);       // read off screen
    send_cmd(REQ_PUT_CHAR, 8'h00, '0, '0);
    send_cmd(REQ_PUT_CHAR, 8'hFF, '0, '0);
    send_cmd(REQ_SET_CURSOR, '0, 7'd79, 5'd24);       // bottom right corner
    send_cmd(REQ_PUT_CHAR, "A", '0, '0);              // cursor lands past the last column
    send_cmd(REQ_PUT_CHAR, "B", '0, '0);              // wraps to row 0, column 0
    send_cmd(REQ_SET_CURSOR, '0, 7'd79, 5'd24);
    send_cmd(REQ_PUT_CHAR, "Z", '0, '0);
    send_cmd(REQ_PUT_CHAR, NewlineChar, '0, '0);      // row moves below the screen
    send_cmd(REQ_PUT_CHAR, NewlineChar, '0, '0);      // row saturates
    send_cmd(REQ_BACKSPACE, '0, '0, '0);              // back onto the last row, scan to 'Z'
    send_cmd(REQ_BACKSPACE, '0, '0, '0);              // plain step back
    send_cmd(REQ_SET_CURSOR, '0, 7'd0, 5'd1);
    send_cmd(REQ_BACKSPACE, '0, '0, '0);              // scan row 0 back to the 0xFF byte
    send_cmd(REQ_BACKSPACE, '0, '0, '0);
    send_cmd(REQ_BACKSPACE, '0, '0, '0);              // at home: nothing happens
    send_cmd(REQ_SET_CURSOR, '0, 7'd80, 5'd0);        // column out of range
    send_cmd(REQ_SET_CURSOR, '0, 7'd0, 5'd25);        // row out of range
    send_cmd(REQ_SET_CURSOR, '0, 7'd0, 5'd24);
    send_cmd(REQ_NEWLINE, '0, '0, '0);                // past the last row: clears
    send_cmd(REQ_SET_CURSOR, '0, 7'd0, 5'd1);
    send_cmd(REQ_BACKSPACE, '0, '0, '0);              // scan a blank row down to column 0
    send_cmd(REQ_CLEAR, '0, '0, '0);
    send_cmd(ReqSpareLo, 8'hFF, 7'd127, 5'd31);
    send_cmd(ReqSpareHi, '0, '0, '0);

    // Random phases, each under its own colors; the first four hit the
    // corners of the color space. Colors change only with the block idle.
    for (int unsigned phase = 0; phase < PhaseCount; phase++) begin
      wait_for_results();
      case (phase)
        0: begin fg = '0; bg = '0; end
        1: begin fg = '1; bg = '1; end
        2: begin fg = '1; bg = '0; end
        3: begin fg = '0; bg = '1; end
        default: begin
          fg = ColorW'($urandom);
          bg = ColorW'($urandom);
        end
      endcase
      set_colors(fg, bg);
      if (phase == HoldPhase) long_hold_req = 1'b1;
      quiet     = (phase == PhaseCount - 1);
      phase_end = items_sent + ItemsPerPhase;
      while (items_sent < phase_end) begin
        if ($urandom_range(99, 0) < 15) send_text_line();
        else send_random_cmd();
      end
    end

    // Drain and let the block settle before the verdict
    wait_for_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
